// File: sv/pwdr_pkg.sv
// shared types and constants for the particle wall deposit and rebound block
`default_nettype none
package pwdr_pkg;

  // result kinds carried on the output tuser
  typedef enum logic [1:0] {
    OUT_REBOUND = 2'd0,
    OUT_DEPOSIT = 2'd1,
    OUT_ABORT   = 2'd2
  } outcome_t;

  // configuration register indexes
  localparam logic CFG_DIMENSIONS = 1'b0;
  localparam logic CFG_CRIT_COEFF = 1'b1;

  localparam logic [1:0]  DIMENSIONS_RESET = 2'd3;
  localparam logic [31:0] CRIT_COEFF_RESET = 32'd44217139;

  localparam int DIV_LAT  = 32;
  localparam int SQRT_LAT = 17;

  // item payload traveling beside the divider and the square root
  typedef struct packed {
    logic               valid;
    outcome_t           kind;
    logic               dim2;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [39:0] wx;
    logic signed [39:0] wy;
    logic signed [39:0] wz;
  } pl_t;

endpackage
`default_nettype wire

// File: sv/pwdr_frac_div.sv
// pipelined restoring divider, one quotient bit per stage, floor(num*2^32/den)
`default_nettype none
module pwdr_frac_div (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] num,
  input  wire logic [63:0] den,
  output logic      [31:0] quo
);

  logic [63:0] rem [0:pwdr_pkg::DIV_LAT-1];
  logic [63:0] dn  [0:pwdr_pkg::DIV_LAT-1];
  logic [31:0] q   [0:pwdr_pkg::DIV_LAT-1];

  for (genvar k = 0; k < pwdr_pkg::DIV_LAT; k++) begin : g_stage
    logic [63:0] rem_in;
    logic [63:0] den_in;
    logic [31:0] q_in;
    logic [63:0] sh;
    logic        take;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_rest
      assign rem_in = rem[k-1];
      assign den_in = dn[k-1];
      assign q_in   = q[k-1];
    end

    // shift in a zero, subtract when the shifted remainder reaches the divisor
    assign sh   = {rem_in[62:0], 1'b0};
    assign take = rem_in[63] || (sh >= den_in);

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= take ? (sh - den_in) : sh;
        dn[k]  <= den_in;
        q[k]   <= {q_in[30:0], take};
      end
    end
  end

  assign quo = q[pwdr_pkg::DIV_LAT-1];

endmodule
`default_nettype wire

// File: sv/pwdr_isqrt.sv
// pipelined integer square root, one result bit per stage
`default_nettype none
module pwdr_isqrt (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [32:0] rad,
  output logic      [16:0] root
);

  logic [32:0] xs [0:pwdr_pkg::SQRT_LAT-1];
  logic [34:0] rs [0:pwdr_pkg::SQRT_LAT-1];

  for (genvar k = 0; k < pwdr_pkg::SQRT_LAT; k++) begin : g_stage
    localparam logic [34:0] BIT = 35'd1 << (2 * (pwdr_pkg::SQRT_LAT - 1 - k));
    logic [32:0] x_in;
    logic [34:0] r_in;
    logic [34:0] t;
    logic        ge;

    if (k == 0) begin : g_first
      assign x_in = rad;
      assign r_in = '0;
    end else begin : g_rest
      assign x_in = xs[k-1];
      assign r_in = rs[k-1];
    end

    // trial subtract of res + bit
    assign t  = r_in + BIT;
    assign ge = {2'b00, x_in} >= t;

    always_ff @(posedge clk) begin
      if (en) begin
        xs[k] <= ge ? 33'({2'b00, x_in} - t) : x_in;
        rs[k] <= ge ? ((r_in >> 1) + BIT) : (r_in >> 1);
      end
    end
  end

  assign root = rs[pwdr_pkg::SQRT_LAT-1][16:0];

endmodule
`default_nettype wire

// File: sv/particle_wall_deposit_rebound.sv
// particle wall hit: deposit test against critical velocity, rebound with restitution
// items pass through the input stages, the 32-stage divider
// and the 17-stage square root pipelines, then the scale and output registers
// throughput: one item per cycle; the whole pipeline holds while the output item waits
// reset: synchronous, clears all valid bits and loads dimensions 3, crit_coeff 44217139
`default_nettype none
module particle_wall_deposit_rebound (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // vel_x, vel_y, vel_z, norm_x, norm_y, norm_z, diameter_nm
  input  wire logic [159:0] s_axis_tdata,
  // is_inert
  input  wire logic [0:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // out_vel_x, out_vel_y, out_vel_z, restitution
  output logic      [111:0] m_axis_tdata,
  // outcome
  output logic      [1:0]   m_axis_tuser,
  input  wire logic         cfg_we,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  logic [1:0]  dimensions;
  logic [31:0] crit_coeff;
  logic        adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dimensions <= pwdr_pkg::DIMENSIONS_RESET;
      crit_coeff <= pwdr_pkg::CRIT_COEFF_RESET;
    end else if (cfg_we) begin
      case (cfg_index[0])
        pwdr_pkg::CFG_DIMENSIONS: dimensions <= cfg_data[1:0];
        pwdr_pkg::CFG_CRIT_COEFF: crit_coeff <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole pipeline moves unless the output item is held
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // stage 1: velocity times normal
  logic               s1_valid;
  logic               s1_inert;
  logic signed [31:0] s1_v [0:2];
  logic signed [15:0] s1_n [0:2];
  logic        [15:0] s1_d;
  logic signed [47:0] s1_p [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_inert <= s_axis_tuser[0];
      s1_d     <= s_axis_tdata[159:144];
      for (int i = 0; i < 3; i++) begin
        s1_v[i] <= s_axis_tdata[32*i +: 32];
        s1_n[i] <= s_axis_tdata[96 + 16*i +: 16];
        s1_p[i] <= $signed(s_axis_tdata[32*i +: 32]) * $signed(s_axis_tdata[96 + 16*i +: 16]);
      end
    end
  end

  // stage 2: normal speed and its magnitude
  logic               s2_valid;
  logic               s2_inert;
  logic               s2_dim2;
  logic signed [31:0] s2_v [0:2];
  logic signed [15:0] s2_n [0:2];
  logic        [15:0] s2_d;
  logic signed [49:0] s2_vn;
  logic        [47:0] s2_avn;
  logic signed [49:0] vn_sum;
  logic signed [49:0] vn_neg;
  logic               dim2;

  assign dim2   = (dimensions == 2'd2);
  assign vn_sum = 50'(s1_p[0]) + 50'(s1_p[1]) + (dim2 ? 50'sd0 : 50'(s1_p[2]));
  assign vn_neg = -vn_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_inert <= s1_inert;
      s2_dim2  <= dim2;
      s2_d     <= s1_d;
      s2_v     <= s1_v;
      s2_n     <= s1_n;
      s2_vn    <= vn_sum;
      s2_avn   <= vn_sum[49] ? vn_neg[47:0] : vn_sum[47:0];
    end
  end

  // stage 3: magnitude times diameter in two halves, vn16 times normal
  logic               s3_valid;
  logic               s3_inert;
  logic               s3_dim2;
  logic signed [31:0] s3_v [0:2];
  logic        [15:0] s3_d;
  logic        [39:0] s3_ad_lo;
  logic        [39:0] s3_ad_hi;
  logic signed [51:0] s3_q [0:2];
  logic signed [35:0] vn16;

  assign vn16 = 36'(s2_vn >>> 14);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_inert <= s2_inert;
      s3_dim2  <= s2_dim2;
      s3_d     <= s2_d;
      s3_v     <= s2_v;
      s3_ad_lo <= s2_avn[23:0] * s2_d;
      s3_ad_hi <= s2_avn[47:24] * s2_d;
      for (int i = 0; i < 3; i++) begin
        s3_q[i] <= vn16 * s2_n[i];
      end
    end
  end

  // stage 4: deposit test, divider operands, reflected velocity
  pwdr_pkg::pl_t      s4_pl;
  logic        [63:0] s4_num;
  logic        [63:0] s4_den;
  logic        [63:0] den;
  logic        [63:0] num;
  logic signed [39:0] w [0:2];

  assign den = {s3_ad_hi, 24'd0} + {24'd0, s3_ad_lo};
  assign num = {18'd0, crit_coeff, 14'd0};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w[i] = 40'(((54'(s3_v[i]) <<< 14) - (54'(s3_q[i]) <<< 1)) >>> 14);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_pl.valid <= 1'b0;
    end else if (adv) begin
      s4_pl.valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (!s3_inert) begin
        s4_pl.kind <= pwdr_pkg::OUT_ABORT;
      end else if (s3_d == 16'd0 || den <= num) begin
        s4_pl.kind <= pwdr_pkg::OUT_DEPOSIT;
      end else begin
        s4_pl.kind <= pwdr_pkg::OUT_REBOUND;
      end
      s4_pl.dim2 <= s3_dim2;
      s4_pl.vx   <= s3_v[0];
      s4_pl.vy   <= s3_v[1];
      s4_pl.vz   <= s3_v[2];
      s4_pl.wx   <= w[0];
      s4_pl.wy   <= w[1];
      s4_pl.wz   <= w[2];
      s4_num     <= num;
      s4_den     <= den;
    end
  end

  // velocity ratio vcr/|vn| in Q0.32
  logic [31:0] ratio;

  pwdr_frac_div u_div (
    .clk (clk),
    .en  (adv),
    .num (s4_num),
    .den (s4_den),
    .quo (ratio)
  );

  pwdr_pkg::pl_t dl1 [0:pwdr_pkg::DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < pwdr_pkg::DIV_LAT; k++) begin
        dl1[k].valid <= 1'b0;
      end
    end else if (adv) begin
      dl1[0] <= s4_pl;
      for (int k = 1; k < pwdr_pkg::DIV_LAT; k++) begin
        dl1[k] <= dl1[k-1];
      end
    end
  end

  // ratio squared, then 1 - r^2
  pwdr_pkg::pl_t sq_pl;
  pwdr_pkg::pl_t sub_pl;
  logic [63:0]   r_sq;
  logic [31:0]   sq_r2;
  logic [32:0]   sub_x;

  assign r_sq = ratio * ratio;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_pl.valid  <= 1'b0;
      sub_pl.valid <= 1'b0;
    end else if (adv) begin
      sq_pl  <= dl1[pwdr_pkg::DIV_LAT-1];
      sub_pl <= sq_pl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r2 <= r_sq[63:32];
      sub_x <= 33'h1_0000_0000 - {1'b0, sq_r2};
    end
  end

  // restitution as square root of 1 - r^2
  logic [16:0] root;

  pwdr_isqrt u_sqrt (
    .clk  (clk),
    .en   (adv),
    .rad  (sub_x),
    .root (root)
  );

  pwdr_pkg::pl_t dl2 [0:pwdr_pkg::SQRT_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < pwdr_pkg::SQRT_LAT; k++) begin
        dl2[k].valid <= 1'b0;
      end
    end else if (adv) begin
      dl2[0] <= sub_pl;
      for (int k = 1; k < pwdr_pkg::SQRT_LAT; k++) begin
        dl2[k] <= dl2[k-1];
      end
    end
  end

  // saturate e to Q0.16
  pwdr_pkg::pl_t e_pl;
  logic [15:0]   e_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_pl.valid <= 1'b0;
    end else if (adv) begin
      e_pl <= dl2[pwdr_pkg::SQRT_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_val <= root[16] ? 16'hFFFF : root[15:0];
    end
  end

  // scale reflected velocity by e
  pwdr_pkg::pl_t      mul_pl;
  logic        [15:0] mul_e;
  logic signed [56:0] mul_p [0:2];
  logic signed [16:0] e_s;

  assign e_s = $signed({1'b0, e_val});

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_pl.valid <= 1'b0;
    end else if (adv) begin
      mul_pl <= e_pl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mul_e    <= e_val;
      mul_p[0] <= e_pl.wx * e_s;
      mul_p[1] <= e_pl.wy * e_s;
      mul_p[2] <= e_pl.wz * e_s;
    end
  end

  // saturation to signed 32 bits
  function automatic logic [31:0] sat32(input logic signed [56:0] p);
    logic signed [40:0] s;
    s = 41'(p >>> 16);
    if (s > 41'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (s < -41'sd2147483648) begin
      return 32'h8000_0000;
    end else begin
      return s[31:0];
    end
  endfunction

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= mul_pl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tuser <= mul_pl.kind;
      if (mul_pl.kind == pwdr_pkg::OUT_REBOUND) begin
        m_axis_tdata[31:0]    <= sat32(mul_p[0]);
        m_axis_tdata[63:32]   <= sat32(mul_p[1]);
        m_axis_tdata[95:64]   <= mul_pl.dim2 ? mul_pl.vz : sat32(mul_p[2]);
        m_axis_tdata[111:96]  <= mul_e;
      end else begin
        m_axis_tdata[31:0]    <= mul_pl.vx;
        m_axis_tdata[63:32]   <= mul_pl.vy;
        m_axis_tdata[95:64]   <= mul_pl.vz;
        m_axis_tdata[111:96]  <= 16'd0;
      end
    end
  end

endmodule
`default_nettype wire
